[rtl/core/oprc_pkg.sv]
// Shared constants and codes for the object pool with oldest-slot recycling.
// Imported by the top level; it depends on nothing else.
`default_nettype none

package oprc_pkg;

  // Pool geometry.
  localparam int POOL_SIZE = 64;
  localparam int SLOT_W    = $clog2(POOL_SIZE);
  localparam int COUNT_W   = SLOT_W + 1;

  // Configuration port geometry.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register indexes.
  localparam logic REG_POOL_COUNT = 1'b0;

  // Request kinds.
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_FRESH     = 2'd0,
    ST_RECYCLED  = 2'd1,
    ST_RELEASED  = 2'd2,
    ST_ERROR     = 2'd3
  } status_t;

endpackage

`default_nettype wire

[rtl/core/object_pool_oldest_recycle_core.sv]
// Top level of the object pool allocator: control, state registers and link memories.
// Depends on oprc_pkg and instantiates three oprc_ram memories.
`default_nettype none

// The block hands out and takes back numbered slots from a pool of up to 64. An allocate
// word pops the free stack and appends the slot to the active list as fresh; with no slot
// free it moves the oldest active slot to the newest position and reports it as recycled,
// or reports an error if no slot is active either. A release word unlinks the named active
// slot and pushes it back on the free stack, or reports an error if the slot is not active.
// In the cycle a word is accepted the free stack and both link memories are read through
// their single registered read ports; in the execute state the result is formed and written
// back once the result register is free, after which the next word may be accepted. One
// word is executed at a time; a further word may be accepted while a result waits, but a
// stalled result holds that word's write-back until it is taken. Writing pool_count rebuilds
// the pool with no clearing pass: the free stack is tracked by a low-water mark below which
// entries still hold their initial slot numbers.

module object_pool_oldest_recycle_core
  import oprc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Request channel.
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_kind,
  input  wire logic [SLOT_W-1:0]  in_slot_in,
  // Result channel.
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [SLOT_W-1:0]  out_slot_out,
  output logic      [1:0]         out_status,
  // Configuration port.
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  localparam logic [COUNT_W-1:0] POOL_FULL = COUNT_W'(POOL_SIZE);

  // Control and state registers.
  state_t               state_r,        state_nxt;
  logic                 kind_r,         kind_nxt;
  logic [SLOT_W-1:0]    req_r,          req_nxt;
  logic [COUNT_W-1:0]   pool_count_r,   pool_count_nxt;
  logic [COUNT_W-1:0]   free_top_r,     free_top_nxt;
  logic [COUNT_W-1:0]   low_mark_r,     low_mark_nxt;
  logic [COUNT_W-1:0]   active_total_r, active_total_nxt;
  logic [SLOT_W-1:0]    oldest_r,       oldest_nxt;
  logic [SLOT_W-1:0]    newest_r,       newest_nxt;
  logic [POOL_SIZE-1:0] active_mark_r,  active_mark_nxt;
  logic                 out_valid_r,    out_valid_nxt;
  logic [SLOT_W-1:0]    out_slot_r,     out_slot_nxt;
  status_t              out_status_r,   out_status_nxt;

  // Memory ports.
  logic              rd_en;
  logic [SLOT_W-1:0] fs_raddr, nl_raddr, pl_raddr;
  logic [SLOT_W-1:0] fs_rdata, nl_rdata, pl_rdata;
  logic              fs_we, nl_we, pl_we;
  logic [SLOT_W-1:0] fs_waddr, nl_waddr, pl_waddr;
  logic [SLOT_W-1:0] fs_wdata, nl_wdata, pl_wdata;

  // Helpers.
  logic               in_fire;
  logic               cfg_wr;
  logic               commit;
  logic [COUNT_W-1:0] ft_dec;
  logic [COUNT_W-1:0] total_dec;
  logic [COUNT_W-1:0] cnt_eff;
  logic               pop_initial;
  logic [SLOT_W-1:0]  pop_slot;

  // Handshake decode.
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign commit    = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign out_valid    = out_valid_r;
  assign out_slot_out = out_slot_r;
  assign out_status   = out_status_r;

  // Register readback.
  assign prdata = (paddr[PADDR_W-1] == REG_POOL_COUNT)
                ? PDATA_W'(pool_count_r) : '0;

  // Read addresses are issued in the cycle the word is accepted.
  assign ft_dec    = free_top_r - COUNT_W'(1);
  assign total_dec = active_total_r - COUNT_W'(1);
  assign rd_en     = in_fire;
  assign fs_raddr  = ft_dec[SLOT_W-1:0];
  assign nl_raddr  = (in_kind == KIND_RELEASE) ? in_slot_in : oldest_r;
  assign pl_raddr  = in_slot_in;

  // Entries below the low-water mark were never rewritten and still hold their index.
  assign pop_initial = (ft_dec < low_mark_r);
  assign pop_slot    = pop_initial ? ft_dec[SLOT_W-1:0] : fs_rdata;

  // Saturated slot count for a rebuild.
  assign cnt_eff = (pwdata[COUNT_W-1:0] > POOL_FULL) ? POOL_FULL : pwdata[COUNT_W-1:0];

  // Next-state logic: capture, execute and write back, rebuild.
  always_comb begin
    state_nxt        = state_r;
    kind_nxt         = kind_r;
    req_nxt          = req_r;
    pool_count_nxt   = pool_count_r;
    free_top_nxt     = free_top_r;
    low_mark_nxt     = low_mark_r;
    active_total_nxt = active_total_r;
    oldest_nxt       = oldest_r;
    newest_nxt       = newest_r;
    active_mark_nxt  = active_mark_r;
    out_valid_nxt    = out_valid_r;
    out_slot_nxt     = out_slot_r;
    out_status_nxt   = out_status_r;
    fs_we    = 1'b0;
    fs_waddr = free_top_r[SLOT_W-1:0];
    fs_wdata = req_r;
    nl_we    = 1'b0;
    nl_waddr = newest_r;
    nl_wdata = req_r;
    pl_we    = 1'b0;
    pl_waddr = req_r;
    pl_wdata = newest_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt  = in_kind;
          req_nxt   = in_slot_in;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          case (kind_r)
            KIND_ALLOC: begin
              if (free_top_r != '0) begin
                // Pop a free slot and append it as the newest.
                out_slot_nxt   = pop_slot;
                out_status_nxt = ST_FRESH;
                free_top_nxt   = ft_dec;
                if (pop_initial) begin
                  low_mark_nxt = ft_dec;
                end
                if (active_total_r != '0) begin
                  nl_we    = 1'b1;
                  nl_waddr = newest_r;
                  nl_wdata = pop_slot;
                  pl_we    = 1'b1;
                  pl_waddr = pop_slot;
                  pl_wdata = newest_r;
                end else begin
                  oldest_nxt = pop_slot;
                end
                newest_nxt                = pop_slot;
                active_mark_nxt[pop_slot] = 1'b1;
                active_total_nxt          = active_total_r + COUNT_W'(1);
              end else if (active_total_r != '0) begin
                // No slot free: the oldest slot moves to the newest position.
                out_slot_nxt   = oldest_r;
                out_status_nxt = ST_RECYCLED;
                if (active_total_r > COUNT_W'(1)) begin
                  oldest_nxt = nl_rdata;
                  nl_we      = 1'b1;
                  nl_waddr   = newest_r;
                  nl_wdata   = oldest_r;
                  pl_we      = 1'b1;
                  pl_waddr   = oldest_r;
                  pl_wdata   = newest_r;
                  newest_nxt = oldest_r;
                end
              end else begin
                out_slot_nxt   = '0;
                out_status_nxt = ST_ERROR;
              end
            end
            default: begin
              out_slot_nxt = req_r;
              if (!active_mark_r[req_r]) begin
                out_status_nxt = ST_ERROR;
              end else begin
                // Unlink the slot from its neighbours.
                out_status_nxt = ST_RELEASED;
                if (req_r == oldest_r) begin
                  oldest_nxt = nl_rdata;
                end else begin
                  nl_we    = 1'b1;
                  nl_waddr = pl_rdata;
                  nl_wdata = nl_rdata;
                end
                if (req_r == newest_r) begin
                  newest_nxt = pl_rdata;
                end else begin
                  pl_we    = 1'b1;
                  pl_waddr = nl_rdata;
                  pl_wdata = pl_rdata;
                end
                active_mark_nxt[req_r] = 1'b0;
                active_total_nxt       = total_dec;
                if (total_dec == '0) begin
                  oldest_nxt = '0;
                  newest_nxt = '0;
                end
                // Push it back on the free stack.
                if (free_top_r < POOL_FULL) begin
                  fs_we        = 1'b1;
                  fs_waddr     = free_top_r[SLOT_W-1:0];
                  fs_wdata     = req_r;
                  free_top_nxt = free_top_r + COUNT_W'(1);
                end
              end
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A write to the slot count rebuilds the pool.
    if (cfg_wr && (paddr[PADDR_W-1] == REG_POOL_COUNT)) begin
      pool_count_nxt   = pwdata[COUNT_W-1:0];
      free_top_nxt     = cnt_eff;
      low_mark_nxt     = cnt_eff;
      active_total_nxt = '0;
      oldest_nxt       = '0;
      newest_nxt       = '0;
      active_mark_nxt  = '0;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      pool_count_r   <= POOL_FULL;
      free_top_r     <= POOL_FULL;
      low_mark_r     <= POOL_FULL;
      active_total_r <= '0;
      oldest_r       <= '0;
      newest_r       <= '0;
      active_mark_r  <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      pool_count_r   <= pool_count_nxt;
      free_top_r     <= free_top_nxt;
      low_mark_r     <= low_mark_nxt;
      active_total_r <= active_total_nxt;
      oldest_r       <= oldest_nxt;
      newest_r       <= newest_nxt;
      active_mark_r  <= active_mark_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    kind_r       <= kind_nxt;
    req_r        <= req_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
  end

  // Free stack and the two link memories.
  oprc_ram #(.Depth(POOL_SIZE), .Width(SLOT_W)) u_free_stack (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .re    (rd_en),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  oprc_ram #(.Depth(POOL_SIZE), .Width(SLOT_W)) u_next_link (
    .clk   (clk),
    .we    (nl_we),
    .waddr (nl_waddr),
    .wdata (nl_wdata),
    .re    (rd_en),
    .raddr (nl_raddr),
    .rdata (nl_rdata)
  );

  oprc_ram #(.Depth(POOL_SIZE), .Width(SLOT_W)) u_prev_link (
    .clk   (clk),
    .we    (pl_we),
    .waddr (pl_waddr),
    .wdata (pl_wdata),
    .re    (rd_en),
    .raddr (pl_raddr),
    .rdata (pl_rdata)
  );

`ifndef ASSERT_OFF
  // Free and active slot counts together never exceed the pool size.
  a_slot_conservation: assert property (@(posedge clk) disable iff (!rst_n)
    (free_top_r + active_total_r) <= POOL_FULL)
    else $error("free and active slot counts exceed the pool size");

  // The active count matches the active marks.
  a_mark_count: assert property (@(posedge clk) disable iff (!rst_n)
    COUNT_W'($countones(active_mark_r)) == active_total_r)
    else $error("active count disagrees with active marks");

  // The low-water mark never lies above the free stack top.
  a_low_mark: assert property (@(posedge clk) disable iff (!rst_n)
    low_mark_r <= free_top_r)
    else $error("free stack low-water mark above top");

  // A result appears only after an execute cycle.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result raised without an execute cycle");

  // A slot reported as fresh is active while the result waits.
  a_fresh_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_FRESH)) |-> active_mark_r[out_slot_r])
    else $error("fresh slot is not marked active");
`endif

endmodule

`default_nettype wire

[rtl/core/oprc_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stands alone; it uses no package.
`default_nettype none

module oprc_ram #(
  parameter int Depth = 64,
  parameter int Width = 6
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data register holds its value between reads.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
